@@ design/assert_macros.svh @@
// Assertion helpers for the design files (used by adsr_envelope_step)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/adsr_pkg.sv @@
package adsr_pkg;

  // Q1.24 unity, idle floor (about 0.001) and Q16 unity gain
  localparam logic [24:0] ONE_Q24    = 25'd16777216;
  localparam logic [24:0] IDLE_FLOOR = 25'd16777;
  localparam logic [16:0] GAIN_ONE   = 17'd65536;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_ATTACK  = 3'd1,
    PH_DECAY   = 3'd2,
    PH_SUSTAIN = 3'd3,
    PH_RELEASE = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_KEY_ON  = 2'd1,
    CMD_KEY_OFF = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_ATTACK_STEP   = 3'd0,
    REG_DECAY_STEP    = 3'd1,
    REG_SUSTAIN_STEP  = 3'd2,
    REG_RELEASE_STEP  = 3'd3,
    REG_SUSTAIN_LEVEL = 3'd4,
    REG_TL_GAIN       = 3'd5,
    REG_MODE_FLAGS    = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [24:0] attack_step;
    logic [24:0] decay_step;
    logic [24:0] sustain_step;
    logic [24:0] release_step;
    logic [24:0] sustain_level;
    logic [16:0] tl_gain;
    logic        zero_decay;
    logic        ignore_key_off;
    logic        bypass;
  } cfg_t;

  typedef struct packed {
    logic [24:0] level;
    logic [16:0] gain;
    phase_t      phase;
  } step_res_t;

endpackage

@@ design/adsr_if.sv @@
interface adsr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [24:0] level_in;
  logic [16:0] velocity;

  modport source (output valid, cmd, level_in, velocity, input ready);
  modport sink   (input valid, cmd, level_in, velocity, output ready);
endinterface

interface adsr_out_if;
  logic        valid;
  logic        ready;
  logic [24:0] level_out;
  logic [16:0] note_gain;
  logic [2:0]  phase_out;

  modport source (output valid, level_out, note_gain, phase_out, input ready);
  modport sink   (input valid, level_out, note_gain, phase_out, output ready);
endinterface

@@ design/adsr_calc.sv @@
module adsr_calc (
  input  adsr_pkg::cfg_t      cfg,
  input  adsr_pkg::phase_t    phase,
  input  logic [1:0]          cmd,
  input  logic [24:0]         level_in,
  input  logic [16:0]         velocity,
  output adsr_pkg::step_res_t res
);
  import adsr_pkg::*;

  phase_t      ph;
  logic [24:0] lvl;
  logic [24:0] sl;
  logic [25:0] att_sum;
  logic [25:0] dec_diff;
  logic [24:0] fall_step;
  logic [25:0] floor_lim;
  logic [24:0] fall_lvl;
  phase_t      fall_ph;
  logic [24:0] tick_lvl;
  phase_t      tick_ph;
  logic [33:0] prod;
  logic [17:0] prod_q16;
  logic [16:0] kon_gain;

  // Out-of-range codes and levels
  assign ph  = (phase > PH_RELEASE) ? PH_IDLE : phase;
  assign lvl = (level_in > ONE_Q24) ? ONE_Q24 : level_in;
  assign sl  = (cfg.sustain_level > ONE_Q24) ? ONE_Q24 : cfg.sustain_level;

  assign att_sum  = {1'b0, lvl} + {1'b0, cfg.attack_step};
  assign dec_diff = {1'b0, lvl} - {1'b0, sl};

  // Sustain/release fall: lvl - step <= floor  <=>  lvl <= step + floor
  assign fall_step = (ph == PH_SUSTAIN) ? cfg.sustain_step : cfg.release_step;
  assign floor_lim = {1'b0, fall_step} + {1'b0, IDLE_FLOOR};
  always_comb begin
    if ({1'b0, lvl} <= floor_lim) begin
      fall_lvl = '0;
      fall_ph  = PH_IDLE;
    end else begin
      fall_lvl = lvl - fall_step;
      fall_ph  = ph;
    end
  end

  // Tick update per phase
  always_comb begin
    tick_lvl = lvl;
    tick_ph  = ph;
    if (cfg.bypass) begin
      tick_lvl = ONE_Q24;
    end else begin
      unique case (ph)
        PH_ATTACK: begin
          if (att_sum >= {1'b0, ONE_Q24}) begin
            tick_lvl = ONE_Q24;
            tick_ph  = PH_DECAY;
          end else begin
            tick_lvl = att_sum[24:0];
          end
        end
        PH_DECAY: begin
          if (cfg.zero_decay) begin
            tick_lvl = ONE_Q24;
            tick_ph  = PH_SUSTAIN;
          end else if (lvl > sl) begin
            if (cfg.decay_step != '0) begin
              if ({1'b0, cfg.decay_step} >= dec_diff) begin
                tick_lvl = sl;
                tick_ph  = PH_SUSTAIN;
              end else begin
                tick_lvl = lvl - cfg.decay_step;
              end
            end
          end else begin
            tick_lvl = sl;
            tick_ph  = PH_SUSTAIN;
          end
        end
        PH_SUSTAIN: begin
          if (cfg.sustain_step != '0) begin
            tick_lvl = fall_lvl;
            tick_ph  = fall_ph;
          end
        end
        PH_RELEASE: begin
          tick_lvl = fall_lvl;
          tick_ph  = fall_ph;
        end
        default: begin
          tick_lvl = lvl;
        end
      endcase
    end
  end

  // Key-on gain: Q16 product truncated and saturated at unity; in bypass, velocity saturated at unity
  assign prod     = 34'(velocity) * 34'(cfg.tl_gain);
  assign prod_q16 = prod[33:16];
  always_comb begin
    if (cfg.bypass) begin
      kon_gain = (velocity > GAIN_ONE) ? GAIN_ONE : velocity;
    end else begin
      kon_gain = (prod_q16 > {1'b0, GAIN_ONE}) ? GAIN_ONE : prod_q16[16:0];
    end
  end

  // Command decode
  always_comb begin
    res.level = lvl;
    res.gain  = '0;
    res.phase = ph;
    unique case (cmd_t'(cmd))
      CMD_TICK: begin
        res.level = tick_lvl;
        res.phase = tick_ph;
      end
      CMD_KEY_ON: begin
        res.gain = kon_gain;
        if (!cfg.bypass) res.phase = PH_ATTACK;
      end
      CMD_KEY_OFF: begin
        if (!cfg.bypass && !cfg.ignore_key_off) res.phase = PH_RELEASE;
      end
      default: begin
        res.phase = ph;
      end
    endcase
  end

endmodule

@@ design/adsr_envelope_step.sv @@
// An input transaction passes through the input register, then the result register.
// One transaction per cycle while the output is not stalled; the envelope phase update and the
// key-on gain multiply sit in one combinational pass between the two registers.
// Reset (synchronous, rst_n low): both stages empty, phase idle, steps and
// sustain level zero, total-level gain unity, mode flags clear.
`include "assert_macros.svh"

module adsr_envelope_step (
  input  logic                  clk,
  input  logic                  rst_n,
  adsr_in_if.sink               in_ch,
  adsr_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_idx,
  input  logic [24:0]           cfg_wdata
);
  import adsr_pkg::*;

  cfg_t        cfg_r;
  phase_t      phase_r;
  logic        s1_valid_r;
  logic [1:0]  s1_cmd_r;
  logic [24:0] s1_level_r;
  logic [16:0] s1_vel_r;
  logic        out_valid_r;
  step_res_t   out_res_r;
  step_res_t   calc_res;
  logic        out_free;
  logic        s1_fire;
  logic        in_fire;
  logic        s1_no_kon;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.attack_step    <= '0;
      cfg_r.decay_step     <= '0;
      cfg_r.sustain_step   <= '0;
      cfg_r.release_step   <= '0;
      cfg_r.sustain_level  <= '0;
      cfg_r.tl_gain        <= GAIN_ONE;
      cfg_r.zero_decay     <= 1'b0;
      cfg_r.ignore_key_off <= 1'b0;
      cfg_r.bypass         <= 1'b0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_idx))
        REG_ATTACK_STEP:   cfg_r.attack_step   <= cfg_wdata;
        REG_DECAY_STEP:    cfg_r.decay_step    <= cfg_wdata;
        REG_SUSTAIN_STEP:  cfg_r.sustain_step  <= cfg_wdata;
        REG_RELEASE_STEP:  cfg_r.release_step  <= cfg_wdata;
        REG_SUSTAIN_LEVEL: cfg_r.sustain_level <= cfg_wdata;
        REG_TL_GAIN:       cfg_r.tl_gain       <= cfg_wdata[16:0];
        REG_MODE_FLAGS: begin
          cfg_r.bypass         <= cfg_wdata[0];
          cfg_r.ignore_key_off <= cfg_wdata[1];
          cfg_r.zero_decay     <= cfg_wdata[2];
        end
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  // Pipeline handshake
  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_fire     = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || out_free;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r   <= in_ch.cmd;
      s1_level_r <= in_ch.level_in;
      s1_vel_r   <= in_ch.velocity;
    end
  end

  adsr_calc u_calc (
    .cfg      (cfg_r),
    .phase    (phase_r),
    .cmd      (s1_cmd_r),
    .level_in (s1_level_r),
    .velocity (s1_vel_r),
    .res      (calc_res)
  );

  // Phase state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_fire) phase_r <= calc_res.phase;
      if (out_free) out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) out_res_r <= calc_res;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.level_out = out_res_r.level;
  assign out_ch.note_gain = out_res_r.gain;
  assign out_ch.phase_out = out_res_r.phase;

  // Checks
  assign s1_no_kon = s1_fire && (s1_cmd_r != CMD_KEY_ON);

  `ASSERT_NEXT(a_stage_moves, clk, rst_n, s1_fire, out_valid_r, "result lost after stage")
  `ASSERT_SAME(a_level_range, clk, rst_n, out_valid_r, out_res_r.level <= ONE_Q24, "level > one")
  `ASSERT_NEXT(a_gain_keyon, clk, rst_n, s1_no_kon, out_res_r.gain == '0, "gain without key-on")

endmodule
